// File: hdl/pld_pkg.sv
// shared types and constants of the paired lz byte decoder
// no dependencies; compile first
package pld_pkg;

   localparam int HISTORY_DEPTH_DEF = 256;
   localparam int BYTE_W            = 8;
   localparam int COUNT_W           = 16;
   localparam int TOTAL_W           = COUNT_W + 1;
   localparam int RUN_W             = 4;
   localparam int DIST_W            = 9;
   localparam int DBITS_W           = 7;
   localparam int CSR_ADDR_W        = 3;
   localparam int CSR_DATA_W        = 32;

   localparam logic [RUN_W-1:0]   LEN_BIAS            = RUN_W'(2);
   localparam logic [DIST_W-1:0]  DIST_BIAS           = DIST_W'(1);
   localparam logic [BYTE_W-1:0]  LITERAL_BIAS_RESET  = '0;
   localparam logic [COUNT_W-1:0] OUTPUT_LENGTH_RESET = 16'hFFFF;

   // register index codes
   localparam logic REG_LITERAL_BIAS  = 1'b0;
   localparam logic REG_OUTPUT_LENGTH = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LIT,
      ST_READ,
      ST_WRITE
   } state_type;

   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,
      PH_PACKED = 2'd1,
      PH_SECOND = 2'd2
   } phase_type;

endpackage

// File: hdl/pld_if.sv
// transfer channels of the paired lz byte decoder
// depends on pld_pkg
interface pld_req_if;
   import pld_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] source_byte;
   modport source (output valid, output source_byte, input ready);
   modport sink (input valid, input source_byte, output ready);
endinterface

interface pld_rsp_if;
   import pld_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last_of_run;
   logic              block_done;
   modport source (output valid, output out_byte, output last_of_run, output block_done,
                   input ready);
   modport sink (input valid, input out_byte, input last_of_run, input block_done,
                 output ready);
endinterface

// File: hdl/paired_lz_byte_decoder_top.sv
// paired lz byte decoder: byte-serial lz decoder with a history ring memory
// depends on pld_pkg and the channel interfaces in pld_if
//
//   channel | dir | handshake              | payload
//   req     | in  | valid / ready          | source_byte
//   rsp     | out | valid / ready          | out_byte, last_of_run, block_done
//   csr     | in  | psel / penable / pready| paddr, pwdata, prdata
//
// a control byte that waits for its packed byte only moves the phase on, a literal
// passes through ST_LIT, and each copied byte is a ring read then a ring write
// after reset a clearing pass zeroes the ring, with req.ready low
// a full output register that is not taken stalls the copy or literal in place
module paired_lz_byte_decoder_top #(
   parameter int HISTORY_DEPTH = pld_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   pld_req_if.sink                         req,
   pld_rsp_if.source                       rsp,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [pld_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [pld_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [pld_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import pld_pkg::*;

   localparam int IDX_W = $clog2(HISTORY_DEPTH);
   localparam int EXT_W = IDX_W + 1;
   localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(HISTORY_DEPTH - 1);
   localparam logic [EXT_W-1:0] DEPTH_EXT = EXT_W'(HISTORY_DEPTH);

   logic [BYTE_W-1:0] ring_mem [HISTORY_DEPTH];

   state_type          state_ff, state_in;
   phase_type          phase_ff, phase_in;
   phase_type          next_phase_ff, next_phase_in;
   logic [DBITS_W-1:0] held_dist_ff, held_dist_in;
   logic [BYTE_W-1:0]  held_packed_ff, held_packed_in;
   logic [IDX_W-1:0]   wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]   src_ff, src_in;
   logic [IDX_W-1:0]   clr_idx_ff, clr_idx_in;
   logic [COUNT_W-1:0] produced_ff, produced_in;
   logic [TOTAL_W-1:0] run_count_ff, run_count_in;
   logic [RUN_W-1:0]   remaining_ff, remaining_in;
   logic [BYTE_W-1:0]  lit_val_ff, lit_val_in;
   logic [BYTE_W-1:0]  bias_ff, bias_in;
   logic [COUNT_W-1:0] length_ff, length_in;
   logic [BYTE_W-1:0]  rd_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  out_byte_ff, out_byte_in;
   logic               last_ff, last_in;
   logic               done_ff, done_in;

   logic [BYTE_W-1:0]  in_byte;
   logic               accept;
   logic               out_free;
   logic               emit;
   logic               run_last;
   logic               run_done;
   logic [TOTAL_W-1:0] run_total;
   logic [BYTE_W-1:0]  emit_byte;
   logic [RUN_W-1:0]   len_first, len_second, copy_len;
   logic [DIST_W-1:0]  dist_first, dist_second, copy_dist;
   logic [EXT_W-1:0]   wr_ext, dist_ext;
   logic [IDX_W-1:0]   src_start;
   logic [BYTE_W-1:0]  literal_out;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_wa;
   logic [BYTE_W-1:0]  mem_wd;
   logic               cfg_we;
   logic               csr_index;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1];
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_index == REG_OUTPUT_LENGTH) ? CSR_DATA_W'(length_ff)
                                                        : CSR_DATA_W'(bias_ff);

   // decode of the incoming byte
   assign in_byte     = req.source_byte;
   assign accept      = req.valid && req.ready;
   assign len_first   = RUN_W'(in_byte[7:5]) + LEN_BIAS;
   assign len_second  = RUN_W'(held_packed_ff[3:1]) + LEN_BIAS;
   assign dist_first  = {held_dist_ff, in_byte[4]} + DIST_BIAS;
   assign dist_second = {in_byte[DBITS_W-1:0], held_packed_ff[0]} + DIST_BIAS;
   assign copy_len    = (phase_ff == PH_PACKED) ? len_first : len_second;
   assign copy_dist   = (phase_ff == PH_PACKED) ? dist_first : dist_second;
   assign wr_ext      = EXT_W'(wr_idx_ff);
   assign dist_ext    = EXT_W'(copy_dist);
   assign src_start   = (wr_ext >= dist_ext) ? IDX_W'(wr_ext - dist_ext)
                                             : IDX_W'(wr_ext + DEPTH_EXT - dist_ext);
   assign literal_out = (in_byte == '0) ? '0 : in_byte + bias_ff;

   // emission of one result byte
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign emit      = out_free && (state_ff == ST_LIT || state_ff == ST_WRITE);
   assign emit_byte = (state_ff == ST_LIT) ? lit_val_ff : rd_data_ff;
   assign run_last  = (state_ff == ST_LIT) || (remaining_ff == RUN_W'(1));
   assign run_total = run_count_ff + TOTAL_W'(1);
   assign run_done  = run_last && (run_total >= TOTAL_W'(length_ff));

   assign req.ready       = (state_ff == ST_IDLE);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_byte    = out_byte_ff;
   assign rsp.last_of_run = last_ff;
   assign rsp.block_done  = done_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_idx_ff == IDX_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               priority if (phase_ff == PH_PACKED) state_in = ST_READ;
               else if (!in_byte[7])               state_in = ST_LIT;
               else if (phase_ff == PH_SECOND)     state_in = ST_READ;
               else                                state_in = ST_IDLE;
            end
         end
         ST_LIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         ST_READ: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (out_free) state_in = run_last ? ST_IDLE : ST_READ;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and register updates
   always_comb begin
      phase_in       = phase_ff;
      next_phase_in  = next_phase_ff;
      held_dist_in   = held_dist_ff;
      held_packed_in = held_packed_ff;
      wr_idx_in      = wr_idx_ff;
      src_in         = src_ff;
      clr_idx_in     = clr_idx_ff;
      produced_in    = produced_ff;
      run_count_in   = run_count_ff;
      remaining_in   = remaining_ff;
      lit_val_in     = lit_val_ff;
      bias_in        = bias_ff;
      length_in      = length_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      out_byte_in    = out_byte_ff;
      last_in        = last_ff;
      done_in        = done_ff;
      mem_we         = 1'b0;
      mem_wa         = wr_idx_ff;
      mem_wd         = emit_byte;

      if (cfg_we) begin
         if (csr_index == REG_OUTPUT_LENGTH) length_in = csr_pwdata[COUNT_W-1:0];
         else                                bias_in   = csr_pwdata[BYTE_W-1:0];
      end

      if (state_ff == ST_CLEAR) begin
         mem_we     = 1'b1;
         mem_wa     = clr_idx_ff;
         mem_wd     = '0;
         clr_idx_in = (clr_idx_ff == IDX_LAST) ? '0 : clr_idx_ff + IDX_W'(1);
      end

      if (accept) begin
         priority if (phase_ff == PH_PACKED) begin
            held_packed_in = in_byte;
            remaining_in   = copy_len;
            src_in         = src_start;
            run_count_in   = TOTAL_W'(produced_ff);
            next_phase_in  = PH_SECOND;
         end else if (!in_byte[7]) begin
            lit_val_in    = literal_out;
            run_count_in  = TOTAL_W'(produced_ff);
            next_phase_in = (phase_ff == PH_SECOND) ? PH_SECOND : PH_FIRST;
         end else if (phase_ff == PH_SECOND) begin
            held_dist_in  = in_byte[DBITS_W-1:0];
            remaining_in  = copy_len;
            src_in        = src_start;
            run_count_in  = TOTAL_W'(produced_ff);
            next_phase_in = PH_FIRST;
         end else begin
            held_dist_in = in_byte[DBITS_W-1:0];
            phase_in     = PH_PACKED;
         end
      end

      if (emit) begin
         mem_we       = 1'b1;
         wr_idx_in    = (wr_idx_ff == IDX_LAST) ? '0 : wr_idx_ff + IDX_W'(1);
         src_in       = (src_ff == IDX_LAST) ? '0 : src_ff + IDX_W'(1);
         remaining_in = remaining_ff - RUN_W'(1);
         run_count_in = run_total;
         rsp_valid_in = 1'b1;
         out_byte_in  = emit_byte;
         last_in      = run_last;
         done_in      = run_done;
         if (run_last) begin
            if (run_done) begin
               produced_in = '0;
               phase_in    = PH_FIRST;
            end else begin
               produced_in = run_total[COUNT_W-1:0];
               phase_in    = next_phase_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         phase_ff       <= PH_FIRST;
         held_dist_ff   <= '0;
         held_packed_ff <= '0;
         wr_idx_ff      <= '0;
         clr_idx_ff     <= '0;
         produced_ff    <= '0;
         bias_ff        <= LITERAL_BIAS_RESET;
         length_ff      <= OUTPUT_LENGTH_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         held_dist_ff   <= held_dist_in;
         held_packed_ff <= held_packed_in;
         wr_idx_ff      <= wr_idx_in;
         clr_idx_ff     <= clr_idx_in;
         produced_ff    <= produced_in;
         bias_ff        <= bias_in;
         length_ff      <= length_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      next_phase_ff <= next_phase_in;
      src_ff        <= src_in;
      run_count_ff  <= run_count_in;
      remaining_ff  <= remaining_in;
      lit_val_ff    <= lit_val_in;
      out_byte_ff   <= out_byte_in;
      last_ff       <= last_in;
      done_ff       <= done_in;
   end

   // history ring
   always_ff @(posedge clock) begin
      if (mem_we) ring_mem[mem_wa] <= mem_wd;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) rd_data_ff <= ring_mem[src_ff];
   end

`ifndef SYNTH
   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.block_done |-> rsp.last_of_run)
      else $error("block_done without last_of_run");

   a_copy_not_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ || state_ff == ST_WRITE) |-> remaining_ff != '0)
      else $error("copy running with no bytes left");

   a_packed_starts_copy: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_PACKED |=> state_ff == ST_READ)
      else $error("packed byte did not start a copy");

   a_block_restart: assert property (@(posedge clock) disable iff (reset)
      emit && run_done |=> produced_ff == '0 && phase_ff == PH_FIRST && rsp.block_done)
      else $error("block end did not restart decoding");
`endif

endmodule

// File: sim/pld_checker.sv
// checker for the paired lz byte decoder: watches the csr, req and rsp channels,
// predicts the decoded bytes and compares every rsp transfer against them
// depends on pld_pkg and the channel interfaces in pld_if
module pld_checker (
   input  logic                           clock,
   input  logic                           reset,
   pld_req_if                             req,
   pld_rsp_if                             rsp,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [pld_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [pld_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                           csr_pready,
   output int                             pending = 0,
   output int                             mismatch_count = 0
);
   timeunit 1ns;
   timeprecision 1ps;
   import pld_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last_of_run;
      logic              block_done;
   } decoded_byte_type;

   decoded_byte_type   expected_bytes[$];
   int                 errors = 0;

   logic [BYTE_W-1:0]  bias;
   logic [COUNT_W-1:0] out_len;
   phase_type          dec_phase;
   logic [DBITS_W-1:0] held_dist;
   logic [BYTE_W-1:0]  held_packed;
   logic [BYTE_W-1:0]  ring[HISTORY_DEPTH_DEF];
   logic [BYTE_W-1:0]  wr_idx;
   logic [COUNT_W-1:0] produced;

   task automatic emit_byte(input logic [BYTE_W-1:0] value, ref decoded_byte_type run[$]);
      decoded_byte_type r;
      ring[wr_idx] = value;
      wr_idx++;
      r.out_byte    = value;
      r.last_of_run = 1'b0;
      r.block_done  = 1'b0;
      run.push_back(r);
   endtask

   task automatic copy_bytes(input int len, input logic [DIST_W-1:0] distance,
                             ref decoded_byte_type run[$]);
      logic [BYTE_W-1:0] src;
      src = wr_idx - distance[BYTE_W-1:0];
      repeat (len) begin
         emit_byte(ring[src], run);
         src++;
      end
   endtask

   task automatic decode_byte(input logic [BYTE_W-1:0] b);
      decoded_byte_type   run[$];
      phase_type          next_phase;
      logic [TOTAL_W-1:0] total;
      next_phase = PH_FIRST;
      if (dec_phase == PH_PACKED) begin
         held_packed = b;
         copy_bytes(int'(b >> 5) + 2, DIST_W'({held_dist, b[4]}) + DIST_W'(1), run);
         next_phase = PH_SECOND;
      end else if (!b[7]) begin
         emit_byte((b == '0) ? '0 : BYTE_W'(b + bias), run);
         next_phase = dec_phase;
      end else if (dec_phase == PH_SECOND) begin
         held_dist = b[DBITS_W-1:0];
         copy_bytes(int'(held_packed[3:1]) + 2,
                    DIST_W'({b[DBITS_W-1:0], held_packed[0]}) + DIST_W'(1), run);
         next_phase = PH_FIRST;
      end else begin
         held_dist = b[DBITS_W-1:0];
         dec_phase = PH_PACKED;
      end
      if (run.size() > 0) begin
         run[run.size()-1].last_of_run = 1'b1;
         total = TOTAL_W'(produced) + TOTAL_W'(run.size());
         if (total >= TOTAL_W'(out_len)) begin
            run[run.size()-1].block_done = 1'b1;
            produced  = '0;
            dec_phase = PH_FIRST;
         end else begin
            produced  = total[COUNT_W-1:0];
            dec_phase = next_phase;
         end
         foreach (run[i]) expected_bytes.push_back(run[i]);
      end
   endtask

   task automatic check_result();
      decoded_byte_type exp_b;
      if (expected_bytes.size() == 0) begin
         $error("rsp transfer with no byte expected: out_byte %02h", rsp.out_byte);
         errors++;
      end else begin
         exp_b = expected_bytes.pop_front();
         if (rsp.out_byte !== exp_b.out_byte) begin
            $error("out_byte: expected %02h, got %02h", exp_b.out_byte, rsp.out_byte);
            errors++;
         end
         if (rsp.last_of_run !== exp_b.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", exp_b.last_of_run, rsp.last_of_run);
            errors++;
         end
         if (rsp.block_done !== exp_b.block_done) begin
            $error("block_done: expected %0b, got %0b", exp_b.block_done, rsp.block_done);
            errors++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         bias        = LITERAL_BIAS_RESET;
         out_len     = OUTPUT_LENGTH_RESET;
         dec_phase   = PH_FIRST;
         held_dist   = '0;
         held_packed = '0;
         wr_idx      = '0;
         produced    = '0;
         foreach (ring[i]) ring[i] = '0;
         expected_bytes.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if ((csr_paddr >> 2) == CSR_ADDR_W'(REG_LITERAL_BIAS))
               bias = csr_pwdata[BYTE_W-1:0];
            else if ((csr_paddr >> 2) == CSR_ADDR_W'(REG_OUTPUT_LENGTH))
               out_len = csr_pwdata[COUNT_W-1:0];
         end
         if (rsp.valid && rsp.ready) check_result();
         if (req.valid && req.ready) decode_byte(req.source_byte);
      end
      pending        <= expected_bytes.size();
      mismatch_count <= errors;
   end

endmodule

// File: sim/tb.sv
// testbench top of the paired lz byte decoder: reset, csr writes, directed and
// random source bytes in bursts, rsp stalls, watchdog and verdict
// depends on pld_pkg, pld_if, paired_lz_byte_decoder_top and pld_checker
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pld_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int NUM_PHASES     = 8;
   localparam int PHASE_ITEMS    = 50;

   typedef enum int {
      READY_ALWAYS,
      READY_RANDOM,
      READY_PATTERN
   } ready_mode_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic                  sink_ready = 1'b0;
   ready_mode_type        ready_mode = READY_ALWAYS;
   int                    ready_tick = 0;
   int                    idle_cycles = 0;
   int                    pending;
   int                    mismatch_count;

   int                    burst_left = 0;
   bit                    gaps_on = 1'b0;
   int                    items_sent = 0;

   pld_req_if req_ch();
   pld_rsp_if rsp_ch();

   assign rsp_ch.ready = sink_ready;

   paired_lz_byte_decoder_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   pld_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req            (req_ch),
      .rsp            (rsp_ch),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .pending        (pending),
      .mismatch_count (mismatch_count)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      ready_tick <= ready_tick + 1;
      case (ready_mode)
         READY_ALWAYS: sink_ready <= 1'b1;
         READY_RANDOM: sink_ready <= ($urandom_range(0, 3) != 0);
         default:      sink_ready <= ((ready_tick % 13) > 4);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   task automatic csr_write(input logic reg_idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(reg_idx) << 2;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic push_byte(input logic [BYTE_W-1:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if (gaps_on) begin
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
               req_ch.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      burst_left--;
      req_ch.valid       <= 1'b1;
      req_ch.source_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   function automatic logic [BYTE_W-1:0] random_literal();
      return ($urandom_range(0, 7) == 0) ? 8'h00 : BYTE_W'($urandom_range(1, 127));
   endfunction

   // mostly whole copy pairs with literals between, some raw noise
   task automatic random_sequence();
      int n;
      if ($urandom_range(0, 4) != 0) begin
         push_byte(8'h80 | BYTE_W'($urandom_range(0, 127)));
         push_byte(BYTE_W'($urandom_range(0, 255)));
         n = $urandom_range(0, 3);
         repeat (n) push_byte(random_literal());
         push_byte(8'h80 | BYTE_W'($urandom_range(0, 127)));
      end else begin
         n = $urandom_range(1, 3);
         repeat (n) push_byte(BYTE_W'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      logic [BYTE_W-1:0]  directed_bytes[20];
      logic [BYTE_W-1:0]  bias_plan[NUM_PHASES];
      logic [COUNT_W-1:0] length_plan[NUM_PHASES];
      logic [BYTE_W-1:0]  bias;
      logic [COUNT_W-1:0] len;
      int                 phase_end;

      directed_bytes = '{8'h00, 8'h7F, 8'h01, 8'h40, 8'h80, 8'hFF, 8'h05, 8'h7F,
                         8'hFF, 8'hFF, 8'h00, 8'h80, 8'h81, 8'h11, 8'h81, 8'h80,
                         8'hEE, 8'h2A, 8'h00, 8'h80};
      bias_plan   = '{8'h00, 8'hFF, 8'h5A, 8'h01, 8'h00, 8'h00, 8'h80, 8'h00};
      length_plan = '{16'd1, 16'hFFFF, 16'd3, 16'd20, 16'd0, 16'd2, 16'd0, 16'hFFFF};

      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.source_byte <= '0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_write(REG_LITERAL_BIAS, CSR_DATA_W'(8'hFF));
      csr_write(REG_OUTPUT_LENGTH, CSR_DATA_W'(16'hFFFF));
      foreach (directed_bytes[i]) push_byte(directed_bytes[i]);
      wait_drained();

      for (int p = 0; p < NUM_PHASES; p++) begin
         bias = (p == 4 || p == 5) ? BYTE_W'($urandom_range(0, 255)) : bias_plan[p];
         case (p)
            4:       len = COUNT_W'($urandom_range(1, 64));
            6:       len = COUNT_W'($urandom_range(1, 65535));
            default: len = length_plan[p];
         endcase
         csr_write(REG_LITERAL_BIAS, CSR_DATA_W'(bias));
         csr_write(REG_OUTPUT_LENGTH, CSR_DATA_W'(len));
         ready_mode <= ready_mode_type'(p % 3);
         gaps_on    = (p % 4 != 3);
         burst_left = 0;
         phase_end  = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            random_sequence();
            if ($urandom_range(0, 19) == 0) wait_drained();
         end
         wait_drained();
      end

      if (mismatch_count == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: paired_lz_byte_decoder_top.f
hdl/pld_pkg.sv
hdl/pld_if.sv
hdl/paired_lz_byte_decoder_top.sv
sim/pld_checker.sv
sim/tb.sv
